// ===== rtl/can_blm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the CAN bus load meter.
// Holds the field widths, estimation constants and the command and status
// structs shared by the controller and the datapath. Depends on nothing.

package can_blm_pkg;

   // Field widths of the channels.
   localparam int RATE_WIDTH   = 20;
   localparam int LEN_WIDTH    = 4;
   localparam int LOAD_WIDTH   = 8;
   localparam int REPORT_WIDTH = 24;

   // Capacity per quarter second is the bit rate shifted down by two.
   localparam int CAP_SHIFT = 2;
   localparam int CAP_WIDTH = RATE_WIDTH - CAP_SHIFT;

   // Bits needed to hold the percent scale factor.
   localparam int SCALE_WIDTH = 7;

   // Reset value of the bit rate register.
   localparam logic [RATE_WIDTH-1:0] RATE_RESET = 20'd500000;

   // Frame bit estimate terms.
   localparam logic [7:0] FRAME_BASE_BITS = 8'd41;
   localparam logic [7:0] BITS_PER_BYTE   = 8'd9;
   localparam logic [7:0] EXT_ID_BITS     = 8'd18;

   // Percent scale and sample ceiling.
   localparam logic [SCALE_WIDTH-1:0] PERCENT_SCALE = 7'd100;
   localparam logic [LOAD_WIDTH-1:0]  SAMPLE_MAX    = 8'd255;

   // Quotient bits produced by the divider, one per step.
   localparam int DIV_STEPS      = LOAD_WIDTH;
   localparam int DIV_STEP_WIDTH = $clog2(DIV_STEPS);

   // Codes of the action field.
   localparam logic ACTION_FRAME = 1'b0;
   localparam logic ACTION_TICK  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the input item fields
      logic add_frame;   // add the frame estimate to the accumulator
      logic scale;       // register accumulator times the percent scale
      logic check;       // clamp check and divider setup
      logic div_step;    // one restoring division step
      logic update;      // fold the sample into the load, clear the count
      logic emit;        // load the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
   } sts_type;

endpackage : can_blm_pkg

`default_nettype wire

// ===== rtl/can_blm_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the CAN bus load meter: input items,
// result items and bit rate register writes. Uses can_blm_pkg for widths.

interface can_blm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [can_blm_pkg::LEN_WIDTH-1:0]     data_length;
   logic                                  extended_id;

   modport source (output valid, output action, output data_length,
                   output extended_id, input ready);
   modport sink   (input valid, input action, input data_length,
                   input extended_id, output ready);
endinterface : can_blm_req_if

interface can_blm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [can_blm_pkg::LOAD_WIDTH-1:0]    load_percent;
   logic [can_blm_pkg::REPORT_WIDTH-1:0]  bits_counted;

   modport source (output valid, output load_percent, output bits_counted,
                   input ready);
   modport sink   (input valid, input load_percent, input bits_counted,
                   output ready);
endinterface : can_blm_rsp_if

interface can_blm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [can_blm_pkg::RATE_WIDTH-1:0]    can_bit_rate;

   modport source (output valid, output can_bit_rate, input ready);
   modport sink   (input valid, input can_bit_rate, output ready);
endinterface : can_blm_csr_if

`default_nettype wire

// ===== rtl/can_bus_load_meter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CAN bus load meter, top level.
// Input items arrive on req_port: action 0 reports an observed frame with its
// data length and identifier type, action 1 is the quarter-second tick.
// Every item yields exactly one result item on rsp_port with the smoothed load
// in percent and the bits counted so far in the current quarter second.
// csr_port writes the nominal bit rate; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// Items are handled one at a time. A frame passes the add state and the emit
// state. A tick passes scaling, the clamp check, the 8-step restoring divider
// that turns the bit count into a percentage of the quarter-second capacity,
// the load update and the emit state. The next item is taken only after a
// result is loaded, so no new item enters before the last one is through.
// A result waits in an output register; while it is stalled, the block accepts
// and works one more item, then holds until the result is taken.
// Reset sets the bit rate to 500000, clears the accumulator and the load, and
// empties the output register.
// Uses can_blm_pkg, the channel interfaces, can_blm_ctrl and can_blm_dpath.

module can_bus_load_meter_core #(
   parameter int BIT_COUNT_WIDTH = 24
) (
   input  wire logic     clock,
   input  wire logic     reset,
   can_blm_req_if.sink   req_port,
   can_blm_rsp_if.source rsp_port,
   can_blm_csr_if.sink   csr_port
);

   can_blm_pkg::cmd_type cmd;
   can_blm_pkg::sts_type sts;
   logic                 csr_write;

   // The bit rate register takes a write in every cycle.
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid;

   // Sequencer.
   can_blm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Counting, division and smoothing.
   can_blm_dpath #(
      .BIT_COUNT_WIDTH (BIT_COUNT_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_port.action),
      .req_data_length  (req_port.data_length),
      .req_extended_id  (req_port.extended_id),
      .csr_write        (csr_write),
      .csr_can_bit_rate (csr_port.can_bit_rate),
      .rsp_load_percent (rsp_port.load_percent),
      .rsp_bits_counted (rsp_port.bits_counted)
   );

endmodule : can_bus_load_meter_core

`default_nettype wire

// ===== rtl/can_blm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Controller of the CAN bus load meter: sequences one item at a time and
// owns the result valid flag. Uses can_blm_pkg for the command structs.

module can_blm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output can_blm_pkg::cmd_type      cmd,
   input  wire can_blm_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCALE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type                               state_ff, state_in;
   logic [can_blm_pkg::DIV_STEP_WIDTH-1:0]  step_ff, step_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state, step count and commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            // The latched action decides between a frame and a tick.
            if (sts.is_tick) begin
               state_in = ST_SCALE;
            end else begin
               cmd.add_frame = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            step_in   = can_blm_pkg::DIV_STEP_WIDTH'(can_blm_pkg::DIV_STEPS - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold here while an earlier result still waits to be taken.
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : can_blm_ctrl

`default_nettype wire

// ===== rtl/can_blm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the CAN bus load meter: bit rate register, bit accumulator,
// smoothed load, restoring divider and output register. Uses can_blm_pkg.

module can_blm_dpath #(
   parameter int BIT_COUNT_WIDTH = 24
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire can_blm_pkg::cmd_type                    cmd,
   output can_blm_pkg::sts_type                         sts,
   input  wire logic                                    req_action,
   input  wire logic [can_blm_pkg::LEN_WIDTH-1:0]       req_data_length,
   input  wire logic                                    req_extended_id,
   input  wire logic                                    csr_write,
   input  wire logic [can_blm_pkg::RATE_WIDTH-1:0]      csr_can_bit_rate,
   output logic [can_blm_pkg::LOAD_WIDTH-1:0]           rsp_load_percent,
   output logic [can_blm_pkg::REPORT_WIDTH-1:0]         rsp_bits_counted
);

   localparam int DW     = BIT_COUNT_WIDTH + can_blm_pkg::SCALE_WIDTH;
   localparam int LW     = can_blm_pkg::LOAD_WIDTH;
   localparam int BLEND_W = LW + 2;

   logic [can_blm_pkg::RATE_WIDTH-1:0] rate_ff;
   logic [BIT_COUNT_WIDTH-1:0]         acc_ff, acc_in;
   logic [LW-1:0]                      load_ff, load_in;
   logic                               tick_ff;
   logic [can_blm_pkg::LEN_WIDTH-1:0]  len_ff;
   logic                               ext_ff;
   logic [DW-1:0]                      prod_ff;
   logic [DW-1:0]                      rem_ff;
   logic [DW-1:0]                      dvs_ff;
   logic [LW-1:0]                      quot_ff;
   logic                               ovf_ff;
   logic [LW-1:0]                      out_load_ff;
   logic [can_blm_pkg::REPORT_WIDTH-1:0] out_bits_ff;

   logic [can_blm_pkg::CAP_WIDTH-1:0]  cap;
   logic                               cap_zero;
   logic                               acc_nz;
   logic [DW-1:0]                      cap_ext;
   logic [7:0]                         frame_bits;
   logic [BIT_COUNT_WIDTH:0]           sum;
   logic                               rem_ge;
   logic [LW-1:0]                      sample;
   logic [BLEND_W-1:0]                 blend;
   logic [LW-1:0]                      blend_load;

   function automatic logic [7:0] req_len_times_nine(
      input logic [can_blm_pkg::LEN_WIDTH-1:0] len
   );
      req_len_times_nine = 8'(len) * can_blm_pkg::BITS_PER_BYTE;
   endfunction

   // Quarter-second capacity.
   assign cap      = rate_ff[can_blm_pkg::RATE_WIDTH-1:can_blm_pkg::CAP_SHIFT];
   assign cap_zero = (cap == '0);
   assign cap_ext  = DW'(cap);
   assign acc_nz   = (acc_ff != '0);

   // Frame estimate and saturating sum.
   assign frame_bits = can_blm_pkg::FRAME_BASE_BITS
                     + 8'(req_len_times_nine(len_ff))
                     + (ext_ff ? can_blm_pkg::EXT_ID_BITS : 8'd0);
   assign sum = {1'b0, acc_ff} + (BIT_COUNT_WIDTH + 1)'(frame_bits);

   // Divider compare for the current step.
   assign rem_ge = (rem_ff >= dvs_ff);

   // Sample and smoothed load for a tick.
   always_comb begin
      if (cap_zero) begin
         sample = acc_nz ? can_blm_pkg::SAMPLE_MAX : '0;
      end else if (ovf_ff) begin
         sample = can_blm_pkg::SAMPLE_MAX;
      end else begin
         sample = quot_ff;
      end
      blend      = BLEND_W'(load_ff) * BLEND_W'(3) + BLEND_W'(sample);
      blend_load = blend[BLEND_W-1:2];
      if (blend_load == '0 && acc_nz) begin
         blend_load = LW'(1);
      end
   end

   // Accumulator and load next values.
   always_comb begin
      acc_in  = acc_ff;
      load_in = load_ff;
      if (cmd.add_frame) begin
         acc_in = sum[BIT_COUNT_WIDTH] ? '1 : sum[BIT_COUNT_WIDTH-1:0];
      end else if (cmd.update) begin
         acc_in  = '0;
         load_in = blend_load;
      end
   end

   // Architectural state: bit rate, accumulator and load.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= can_blm_pkg::RATE_RESET;
         acc_ff  <= '0;
         load_ff <= '0;
      end else begin
         if (csr_write) begin
            rate_ff <= csr_can_bit_rate;
         end
         acc_ff  <= acc_in;
         load_ff <= load_in;
      end
   end

   // Latched item fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tick_ff <= (req_action == can_blm_pkg::ACTION_TICK);
         len_ff  <= req_data_length;
         ext_ff  <= req_extended_id;
      end
   end

   // Scaling, clamp check and restoring divider.
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         prod_ff <= DW'(acc_ff) * DW'(can_blm_pkg::PERCENT_SCALE);
      end
      if (cmd.check) begin
         ovf_ff  <= (prod_ff >= (cap_ext << LW));
         rem_ff  <= prod_ff;
         dvs_ff  <= cap_ext << (LW - 1);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - dvs_ff;
         end
         dvs_ff  <= dvs_ff >> 1;
         quot_ff <= {quot_ff[LW-2:0], rem_ge};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_load_ff <= load_ff;
         out_bits_ff <= can_blm_pkg::REPORT_WIDTH'(acc_ff);
      end
   end

   assign sts.is_tick       = tick_ff;
   assign rsp_load_percent  = out_load_ff;
   assign rsp_bits_counted  = out_bits_ff;

endmodule : can_blm_dpath

`default_nettype wire

// ===== verif/tb_can_bus_load_meter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for can_bus_load_meter_core: frame and tick items
// are checked against a bus load tracker. Bit rate settings vary between phases.
// Depends on can_blm_pkg, the channel interfaces and the core itself.

module tb_can_bus_load_meter_core;

   localparam int ACC_WIDTH    = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PCT     = 8;
   // Length of the closing run of maximum-size frames sent with no idling.
   localparam int BURST_FRAMES = 60;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 62;

   typedef struct packed {
      logic [can_blm_pkg::LOAD_WIDTH-1:0]   load_percent;
      logic [can_blm_pkg::REPORT_WIDTH-1:0] bits_counted;
   } load_report_type;

   // Tracks the expected accumulator and smoothed load, and holds the
   // reports still owed by the block.
   class bus_load_tracker;
      logic [can_blm_pkg::RATE_WIDTH-1:0] bit_rate;
      logic [ACC_WIDTH-1:0]               bit_total;
      logic [can_blm_pkg::LOAD_WIDTH-1:0] load;
      load_report_type                    expected_reports[$];
      int                                 mismatches;

      function new();
         bit_rate   = can_blm_pkg::RATE_RESET;
         bit_total  = '0;
         load       = '0;
         mismatches = 0;
      endfunction

      // Works out the report for one accepted item and queues it.
      function void note_item(logic act, logic [can_blm_pkg::LEN_WIDTH-1:0] len,
                              logic ext);
         logic [ACC_WIDTH:0]                 sum;
         logic [63:0]                        quotient;
         logic [can_blm_pkg::RATE_WIDTH-1:0] capacity;
         logic [can_blm_pkg::LOAD_WIDTH-1:0] sample;
         logic [can_blm_pkg::LOAD_WIDTH+1:0] blended;
         load_report_type                    rpt;
         if (act == can_blm_pkg::ACTION_FRAME) begin
            sum = (ACC_WIDTH+1)'(bit_total)
                  + (ACC_WIDTH+1)'(can_blm_pkg::FRAME_BASE_BITS)
                  + (ACC_WIDTH+1)'(len) * (ACC_WIDTH+1)'(can_blm_pkg::BITS_PER_BYTE)
                  + (ACC_WIDTH+1)'(ext ? can_blm_pkg::EXT_ID_BITS : 8'd0);
            // The count sticks at its maximum instead of wrapping.
            bit_total = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
         end else begin
            capacity = bit_rate >> can_blm_pkg::CAP_SHIFT;
            // With no capacity any traffic at all counts as a full bus.
            if (capacity == 0) begin
               sample = (bit_total != 0) ? can_blm_pkg::SAMPLE_MAX : '0;
            end else begin
               quotient = (64'(bit_total) * 64'(can_blm_pkg::PERCENT_SCALE))
                          / 64'(capacity);
               sample = (quotient > 64'(can_blm_pkg::SAMPLE_MAX))
                        ? can_blm_pkg::SAMPLE_MAX
                        : quotient[can_blm_pkg::LOAD_WIDTH-1:0];
            end
            blended = ((can_blm_pkg::LOAD_WIDTH+2)'(load) * (can_blm_pkg::LOAD_WIDTH+2)'(3)
                       + (can_blm_pkg::LOAD_WIDTH+2)'(sample)) >> 2;
            // Any counted traffic keeps the load off zero.
            if (blended == 0 && bit_total != 0) blended = 1;
            load      = blended[can_blm_pkg::LOAD_WIDTH-1:0];
            bit_total = '0;
         end
         rpt.load_percent = load;
         rpt.bits_counted = bit_total[can_blm_pkg::REPORT_WIDTH-1:0];
         expected_reports.push_back(rpt);
      endfunction

      // Compares one accepted result item with the oldest expected report.
      function void check_report(logic [can_blm_pkg::LOAD_WIDTH-1:0] load_got,
                                 logic [can_blm_pkg::REPORT_WIDTH-1:0] bits_got);
         load_report_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected result item: load_percent %0d, bits_counted %0d",
                   load_got, bits_got);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         if (load_got !== want.load_percent) begin
            $error("load_percent: expected %0d, actual %0d", want.load_percent, load_got);
            mismatches++;
         end
         if (bits_got !== want.bits_counted) begin
            $error("bits_counted: expected %0d, actual %0d", want.bits_counted, bits_got);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet    = 1'b0;
   int   hold_req = 0;
   int   cycle_count;

   bus_load_tracker tracker;

   can_blm_req_if req_if ();
   can_blm_rsp_if rsp_if ();
   can_blm_csr_if csr_if ();

   can_bus_load_meter_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // Free-running clock, 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one item, with a random gap first, and waits until it is taken.
   // Valid is left high so that a following item can go out back to back.
   task automatic send_item(input logic act,
                            input logic [can_blm_pkg::LEN_WIDTH-1:0] len,
                            input logic ext);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.data_length <= len;
      req_if.extended_id <= ext;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      tracker.note_item(act, len, ext);
   endtask

   // Mostly frames of legal length, sometimes oversized ones, with ticks mixed in.
   task automatic send_random_item(input int tick_pct);
      logic                                act;
      logic [can_blm_pkg::LEN_WIDTH-1:0]   len;
      logic                                ext;
      act = ($urandom_range(0, 99) < tick_pct) ? can_blm_pkg::ACTION_TICK
                                               : can_blm_pkg::ACTION_FRAME;
      len = ($urandom_range(0, 4) == 0)
            ? can_blm_pkg::LEN_WIDTH'($urandom_range(9, 15))
            : can_blm_pkg::LEN_WIDTH'($urandom_range(0, 8));
      ext = 1'($urandom_range(0, 1));
      send_item(act, len, ext);
   endtask

   // Stops offering items until every expected report has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (tracker.expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the bit rate register once the block has gone idle.
   task automatic write_rate(input logic [can_blm_pkg::RATE_WIDTH-1:0] rate);
      wait_drained();
      csr_if.valid        <= 1'b1;
      csr_if.can_bit_rate <= rate;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      tracker.bit_rate = rate;
      csr_if.valid <= 1'b0;
   endtask

   // Small rates dominate so that a few dozen frames move the load noticeably.
   function automatic logic [can_blm_pkg::RATE_WIDTH-1:0] pick_rate();
      case ($urandom_range(0, 9))
         0:       return can_blm_pkg::RATE_WIDTH'($urandom_range(0, 3));
         1:       return 20'd1000000;
         2:       return '1;
         3:       return can_blm_pkg::RATE_RESET;
         4:       return can_blm_pkg::RATE_WIDTH'($urandom_range(8001, 1048575));
         default: return can_blm_pkg::RATE_WIDTH'($urandom_range(4, 8000));
      endcase
   endfunction

   // Result side: checks each taken item and stalls at random or on request.
   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            tracker.check_report(rsp_if.load_percent, rsp_if.bits_counted);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Ends a run that hangs.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Stimulus: directed corner cases, random phases, then a burst with no idling.
   initial begin : stimulus
      tracker = new();
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.action       <= can_blm_pkg::ACTION_FRAME;
      req_if.data_length  <= '0;
      req_if.extended_id  <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.can_bit_rate <= can_blm_pkg::RATE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset bit rate: an empty tick, frames of every size class, then a tick whose
      // tiny sample leaves the load forced up to one and an empty tick after it.
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd8, 1'b0);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd8, 1'b1);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd15, 1'b1);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd9, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);

      // Zero capacity: traffic reads as full load, no traffic as none.
      write_rate('0);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd3, 1'b1);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      write_rate(20'd3);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd12, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);

      // Capacity of one bit: the sample clamps at its ceiling.
      write_rate(20'd4);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd15, 1'b1);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);

      // Highest rates; the tick carries junk length and identifier fields.
      write_rate('1);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd8, 1'b1);
      send_item(can_blm_pkg::ACTION_TICK, 4'd15, 1'b1);
      write_rate(20'd1000000);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd1, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd7, 1'b0);

      // Random phases, each at its own bit rate.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_rate(pick_rate());
         // Hold the result side off while items keep coming, to fill the block.
         if (ph == 3) hold_req++;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained();
            send_random_item((ph % 2 == 0) ? 12 : 5);
         end
      end

      // A run of maximum-size frames with no idling on either side, one
      // small frame after it, then two ticks.
      write_rate(20'd1000000);
      quiet = 1'b1;
      repeat (BURST_FRAMES) send_item(can_blm_pkg::ACTION_FRAME, 4'd15, 1'b1);
      send_item(can_blm_pkg::ACTION_FRAME, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      send_item(can_blm_pkg::ACTION_TICK, 4'd0, 1'b0);
      quiet = 1'b0;

      wait_drained();
      if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule : tb_can_bus_load_meter_core
